// ===== hw/rtl/pfdn_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfdn_pkg
// Shared types and constants for the pcm frame downmix normalizer.
// ----------------------------------------------------------------------------
package pfdn_pkg;

	localparam int MAX_CHANNELS = 8;
	localparam int SUM_W        = 35;
	localparam int SAMPLE_W     = 32;
	localparam int CH_W         = 4;
	localparam int DIV_STEPS    = SUM_W;
	localparam int DIV_CNT_W    = $clog2(DIV_STEPS + 1);

	// sample format codes
	localparam logic [1:0] FMT_U8  = 2'd0;
	localparam logic [1:0] FMT_S16 = 2'd1;
	localparam logic [1:0] FMT_S32 = 2'd2;

	// register indexes
	localparam logic REG_SAMPLE_FORMAT = 1'b0;
	localparam logic REG_CHANNEL_COUNT = 1'b1;

	localparam logic [1:0]      FORMAT_RESET  = FMT_S16;
	localparam logic [CH_W-1:0] CHANNEL_RESET = CH_W'(2);

	typedef struct packed {
		logic accept;
		logic div_start;
		logic load_out;
	} pfdn_cmd_t;

	typedef struct packed {
		logic frame_done;
		logic div_done;
		logic out_full;
	} pfdn_status_t;

endpackage

// ===== hw/rtl/pcm_frame_downmix_normalizer_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcm_frame_downmix_normalizer_top
// Byte stream in, channel-averaged mono Q1.31 sample out per frame.
// throughput: one byte per cycle, except that the bit-serial divide stalls intake
//   after each frame until the result is loaded into the output register
// reset: async active low; format 16-bit, two channels, alignment cleared
// ----------------------------------------------------------------------------
module pcm_frame_downmix_normalizer_top (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	input  logic [7:0]                           s_tdata,   // data_byte
	input  logic                                 s_tlast,   // last_byte
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	output logic signed [pfdn_pkg::SAMPLE_W-1:0] m_tdata,   // mono_sample
	input  logic                                 cfg_we,
	input  logic                                 cfg_index,
	input  logic [pfdn_pkg::CH_W-1:0]            cfg_data
);

	pfdn_pkg::pfdn_cmd_t    cmd;
	pfdn_pkg::pfdn_status_t status;

	pfdn_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.out_ready (m_tready),
		.status    (status),
		.cmd       (cmd)
	);

	pfdn_datapath u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.status     (status),
		.data_byte  (s_tdata),
		.last_byte  (s_tlast),
		.out_ready  (m_tready),
		.out_sample (m_tdata),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	assign m_tvalid = status.out_full;

endmodule

// ===== hw/rtl/pfdn_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfdn_div
// Restoring divider, one quotient bit per cycle, signed by magnitude.
// ----------------------------------------------------------------------------
module pfdn_div (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	input  logic signed [pfdn_pkg::SUM_W-1:0]  dividend,
	input  logic [pfdn_pkg::CH_W-1:0]          divisor,
	output logic                               done,
	output logic signed [pfdn_pkg::SAMPLE_W-1:0] quotient
);

	logic [pfdn_pkg::SUM_W-1:0]     mag_q;
	logic [pfdn_pkg::CH_W-1:0]      rem_q;
	logic [pfdn_pkg::CH_W-1:0]      den_q;
	logic [pfdn_pkg::DIV_CNT_W-1:0] cnt_q;
	logic                           neg_q;
	logic                           busy_q;
	logic                           done_q;
	logic [pfdn_pkg::CH_W:0]        trial;
	logic                           fits;
	logic [pfdn_pkg::CH_W:0]        diff;
	logic [pfdn_pkg::SAMPLE_W-1:0]  q_low;
	logic                           last_step;

	assign trial     = {rem_q, mag_q[pfdn_pkg::SUM_W-1]};
	assign fits      = trial >= {1'b0, den_q};
	assign diff      = trial - {1'b0, den_q};
	assign q_low     = mag_q[pfdn_pkg::SAMPLE_W-1:0];
	assign last_step = (cnt_q == pfdn_pkg::DIV_CNT_W'(pfdn_pkg::DIV_STEPS - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			mag_q  <= '0;
			rem_q  <= '0;
			den_q  <= pfdn_pkg::CH_W'(1);
			neg_q  <= 1'b0;
		end else begin
			done_q <= busy_q && !start && last_step;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
				neg_q  <= dividend[pfdn_pkg::SUM_W-1];
				mag_q  <= dividend[pfdn_pkg::SUM_W-1] ? pfdn_pkg::SUM_W'(-dividend)
				                                     : pfdn_pkg::SUM_W'(dividend);
				rem_q  <= '0;
				den_q  <= divisor;
			end else if (busy_q) begin
				rem_q <= fits ? diff[pfdn_pkg::CH_W-1:0] : trial[pfdn_pkg::CH_W-1:0];
				mag_q <= {mag_q[pfdn_pkg::SUM_W-2:0], fits};
				if (last_step) begin
					busy_q <= 1'b0;
				end else begin
					cnt_q <= cnt_q + 1'b1;
				end
			end
		end
	end

	assign done     = done_q;
	assign quotient = neg_q ? -q_low : q_low;

endmodule

// ===== hw/rtl/pfdn_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfdn_datapath
// Config registers, sample assembly, frame accumulation, divider, result reg.
// ----------------------------------------------------------------------------
module pfdn_datapath (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  pfdn_pkg::pfdn_cmd_t                  cmd,
	output pfdn_pkg::pfdn_status_t               status,
	input  logic [7:0]                           data_byte,
	input  logic                                 last_byte,
	input  logic                                 out_ready,
	output logic signed [pfdn_pkg::SAMPLE_W-1:0] out_sample,
	input  logic                                 cfg_we,
	input  logic                                 cfg_index,
	input  logic [pfdn_pkg::CH_W-1:0]            cfg_data
);

	logic [1:0]                           fmt_q;
	logic [pfdn_pkg::CH_W-1:0]            chan_cfg_q;
	logic [1:0]                           bis_q;
	logic [2:0]                           ch_idx_q;
	logic [pfdn_pkg::SAMPLE_W-1:0]        asm_q;
	logic signed [pfdn_pkg::SUM_W-1:0]    sum_q;
	logic signed [pfdn_pkg::SAMPLE_W-1:0] out_q;
	logic                                 out_valid_q;

	logic [2:0]                           nbytes;
	logic [pfdn_pkg::CH_W-1:0]            nch;
	logic [pfdn_pkg::SAMPLE_W-1:0]        asm_next;
	logic [pfdn_pkg::SAMPLE_W-1:0]        scaled;
	logic signed [pfdn_pkg::SUM_W-1:0]    sum_next;
	logic                                 sample_done;
	logic                                 frame_done;
	logic                                 div_done;
	logic signed [pfdn_pkg::SAMPLE_W-1:0] quotient;

	always_comb begin
		case (fmt_q)
			pfdn_pkg::FMT_U8:  nbytes = 3'd1;
			pfdn_pkg::FMT_S16: nbytes = 3'd2;
			default:           nbytes = 3'd4;
		endcase
	end

	always_comb begin
		if (chan_cfg_q == '0)
			nch = pfdn_pkg::CH_W'(1);
		else if (chan_cfg_q > pfdn_pkg::CH_W'(pfdn_pkg::MAX_CHANNELS))
			nch = pfdn_pkg::CH_W'(pfdn_pkg::MAX_CHANNELS);
		else
			nch = chan_cfg_q;
	end

	assign asm_next = asm_q | (pfdn_pkg::SAMPLE_W'(data_byte) << {bis_q, 3'b000});

	always_comb begin
		case (fmt_q)
			pfdn_pkg::FMT_U8:  scaled = {~asm_next[7], asm_next[6:0], 24'd0};
			pfdn_pkg::FMT_S16: scaled = {asm_next[15:0], 16'd0};
			default:           scaled = asm_next;
		endcase
	end

	assign sum_next    = sum_q + pfdn_pkg::SUM_W'($signed(scaled));
	assign sample_done = ({1'b0, bis_q} + 3'd1) >= nbytes;
	assign frame_done  = sample_done && (({1'b0, ch_idx_q} + 4'd1) >= nch);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fmt_q      <= pfdn_pkg::FORMAT_RESET;
			chan_cfg_q <= pfdn_pkg::CHANNEL_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				pfdn_pkg::REG_SAMPLE_FORMAT: fmt_q      <= cfg_data[1:0];
				pfdn_pkg::REG_CHANNEL_COUNT: chan_cfg_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bis_q    <= '0;
			ch_idx_q <= '0;
			asm_q    <= '0;
			sum_q    <= '0;
		end else if (cfg_we || (cmd.accept && last_byte)) begin
			bis_q    <= '0;
			ch_idx_q <= '0;
			asm_q    <= '0;
			sum_q    <= '0;
		end else if (cmd.accept) begin
			if (sample_done) begin
				bis_q    <= '0;
				asm_q    <= '0;
				ch_idx_q <= frame_done ? 3'd0 : ch_idx_q + 3'd1;
				sum_q    <= frame_done ? '0 : sum_next;
			end else begin
				bis_q <= bis_q + 2'd1;
				asm_q <= asm_next;
			end
		end
	end

	pfdn_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (sum_next),
		.divisor  (nch),
		.done     (div_done),
		.quotient (quotient)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_q <= quotient;
		end
	end

	assign status.frame_done = frame_done;
	assign status.div_done   = div_done;
	assign status.out_full   = out_valid_q;
	assign out_sample        = out_q;

endmodule

// ===== hw/rtl/pfdn_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfdn_ctrl
// Sequencer: byte intake, divide wait and result hand-off.
// ----------------------------------------------------------------------------
module pfdn_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic                   out_ready,
	input  pfdn_pkg::pfdn_status_t status,
	output pfdn_pkg::pfdn_cmd_t    cmd
);

	typedef enum logic [2:0] {
		ST_RUN  = 3'b001,
		ST_DIV  = 3'b010,
		ST_HOLD = 3'b100
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   out_free;

	assign out_free      = !status.out_full || out_ready;
	assign in_ready      = (state_q == ST_RUN);
	assign cmd.accept    = in_valid && in_ready;
	assign cmd.div_start = cmd.accept && status.frame_done;
	assign cmd.load_out  = out_free &&
	                       (((state_q == ST_DIV) && status.div_done) || (state_q == ST_HOLD));

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_RUN: begin
				if (cmd.div_start) state_d = ST_DIV;
			end
			ST_DIV: begin
				if (status.div_done) state_d = out_free ? ST_RUN : ST_HOLD;
			end
			ST_HOLD: begin
				if (out_free) state_d = ST_RUN;
			end
			default: state_d = ST_RUN;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_RUN;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ===== sim/pcm_frame_downmix_normalizer_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcm_frame_downmix_normalizer_top_tb
// Streams pcm data bytes into the downmix block under random input gaps and
// output stalls. A local model of sample assembly, q1.31 scaling and frame
// averaging predicts every mono sample. Each result is checked in order.
// Directed items cover full-scale samples, the 8-bit, 16-bit and unused
// format codes, channel counts of zero and above the maximum, end of chunk
// and config writes that drop a partial frame. Random phases sweep the
// settings; two passes apply output back-pressure and a mid-frame drain.
// ----------------------------------------------------------------------------
module pcm_frame_downmix_normalizer_top_tb;
	import pfdn_pkg::*;

	localparam int SETTLE_CYCLES = 45;
	localparam int RAND_PHASES   = 12;
	localparam int PHASE_ITEMS   = 100;

	// unused format code, handled as 32-bit
	localparam logic [1:0] FMT_UNUSED = 2'd3;

	logic                       clk       = 1'b0;
	logic                       arst_n    = 1'b0;
	logic                       s_tvalid  = 1'b0;
	logic                       s_tready;
	logic [7:0]                 s_tdata   = '0;
	logic                       s_tlast   = 1'b0;
	logic                       m_tvalid;
	logic                       m_tready  = 1'b0;
	logic signed [SAMPLE_W-1:0] m_tdata;
	logic                       cfg_we    = 1'b0;
	logic                       cfg_index = 1'b0;
	logic [CH_W-1:0]            cfg_data  = '0;

	pcm_frame_downmix_normalizer_top dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// predictor state
	logic [1:0]      cur_format;
	logic [CH_W-1:0] cur_channels;
	int unsigned     byte_pos;
	int unsigned     chan_pos;
	logic [31:0]     sample_word;
	longint          frame_acc;

	logic signed [SAMPLE_W-1:0] pending_mono[$];
	int err_count     = 0;
	bit gaps_on       = 1'b0;
	int sink_hold_len = 0;

	task automatic note_error(input string msg);
		$display("ERROR at %0t: %s", $time, msg);
		err_count++;
	endtask

	function automatic int pick_gap();
		int r;
		if (!gaps_on)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [7:0] pick_byte();
		case ($urandom_range(0, 15))
			0: return 8'h00;
			1: return 8'hff;
			2: return 8'h80;
			3: return 8'h7f;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	function automatic void clear_alignment();
		byte_pos    = 0;
		chan_pos    = 0;
		sample_word = '0;
		frame_acc   = 0;
	endfunction

	// one data byte through the downmix; returns 1 when a frame completes
	function automatic bit downmix_step(input logic [7:0] b, input logic last,
	                                    output logic signed [SAMPLE_W-1:0] mono);
		int unsigned nbytes;
		int unsigned nch;
		logic [31:0] scaled;
		longint      avg;
		bit          done;
		done = 1'b0;
		mono = '0;
		nbytes = (cur_format == FMT_U8) ? 1 : (cur_format == FMT_S16) ? 2 : 4;
		if (cur_channels == 0)
			nch = 1;
		else if (cur_channels > MAX_CHANNELS)
			nch = MAX_CHANNELS;
		else
			nch = cur_channels;
		sample_word |= 32'(b) << (8 * byte_pos);
		byte_pos++;
		if (byte_pos >= nbytes) begin
			case (cur_format)
				FMT_U8:  scaled = {sample_word[7:0] ^ 8'h80, 24'h0};
				FMT_S16: scaled = {sample_word[15:0], 16'h0};
				default: scaled = sample_word;
			endcase
			frame_acc   = frame_acc + longint'($signed(scaled));
			byte_pos    = 0;
			sample_word = '0;
			chan_pos++;
			if (chan_pos >= nch) begin
				avg       = frame_acc / longint'(nch);
				mono      = avg[31:0];
				done      = 1'b1;
				chan_pos  = 0;
				frame_acc = 0;
			end
		end
		if (last)
			clear_alignment();
		return done;
	endfunction

	// called at a falling edge; returns at a falling edge with valid still up
	task automatic send_byte(input logic [7:0] b, input logic last);
		int gap;
		logic signed [SAMPLE_W-1:0] mono;
		gap = pick_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		s_tlast  <= last;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		if (downmix_step(b, last, mono))
			pending_mono.push_back(mono);
		@(negedge clk);
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		do
			@(negedge clk);
		while (pending_mono.size() != 0);
	endtask

	task automatic set_config(input logic [1:0] fmt, input logic [CH_W-1:0] ch);
		wait_drained();
		repeat (SETTLE_CYCLES) @(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= REG_SAMPLE_FORMAT;
		cfg_data  <= CH_W'(fmt);
		@(negedge clk);
		cfg_index <= REG_CHANNEL_COUNT;
		cfg_data  <= ch;
		@(negedge clk);
		cfg_we <= 1'b0;
		cur_format   = fmt;
		cur_channels = ch;
		clear_alignment();
	endtask

	task automatic send_random(input int count, input int last_odds);
		for (int i = 0; i < count; i++)
			send_byte(pick_byte(), $urandom_range(0, last_odds - 1) == 0);
	endtask

	// reset settings: 16-bit stereo, full-scale negative and positive
	task automatic test_reset_settings();
		send_byte(8'h00, 1'b0);
		send_byte(8'h80, 1'b0);
		send_byte(8'hff, 1'b0);
		send_byte(8'h7f, 1'b0);
	endtask

	task automatic test_format_codes();
		set_config(FMT_U8, CH_W'(1));
		send_byte(8'h00, 1'b0);
		send_byte(8'hff, 1'b1);
		send_byte(8'h80, 1'b0);
		// unused format code acts as 32-bit
		set_config(FMT_UNUSED, CH_W'(1));
		send_byte(8'h00, 1'b0);
		send_byte(8'h00, 1'b0);
		send_byte(8'h00, 1'b0);
		send_byte(8'h80, 1'b0);
	endtask

	task automatic test_channel_limits();
		set_config(FMT_U8, CH_W'(0));
		send_byte(8'h7f, 1'b0);
		// saturates to max channels; most negative sum
		set_config(FMT_U8, CH_W'(15));
		for (int i = 0; i < MAX_CHANNELS; i++)
			send_byte(8'h00, 1'b0);
	endtask

	task automatic test_partial_frames();
		set_config(FMT_S16, CH_W'(2));
		send_byte(8'h34, 1'b0);
		send_byte(8'h12, 1'b1);
		send_byte(8'h55, 1'b0);
		// config write drops the partial sample
		set_config(FMT_U8, CH_W'(3));
		send_byte(8'h01, 1'b0);
		send_byte(8'hfe, 1'b0);
		send_byte(8'h80, 1'b0);
	endtask

	task automatic test_random_phases();
		logic [1:0]      fmt;
		logic [CH_W-1:0] ch;
		for (int p = 0; p < RAND_PHASES; p++) begin
			case (p)
				0: begin fmt = FMT_U8;     ch = CH_W'(1);  end
				1: begin fmt = FMT_S32;    ch = CH_W'(8);  end
				2: begin fmt = FMT_UNUSED; ch = CH_W'(15); end
				3: begin fmt = FMT_S16;    ch = CH_W'(0);  end
				4: begin fmt = FMT_U8;     ch = CH_W'(8);  end
				5: begin fmt = FMT_S32;    ch = CH_W'(1);  end
				default: begin
					fmt = 2'($urandom_range(0, 3));
					if ($urandom_range(0, 4) == 0)
						ch = CH_W'($urandom_range(0, 15));
					else
						ch = CH_W'($urandom_range(1, MAX_CHANNELS));
				end
			endcase
			set_config(fmt, ch);
			gaps_on = (p % 4 != 2);
			send_random(PHASE_ITEMS, 48);
		end
		gaps_on = 1'b1;
	endtask

	task automatic test_output_backpressure();
		set_config(FMT_U8, CH_W'(1));
		gaps_on       = 1'b0;
		sink_hold_len = 400;
		send_random(80, 64);
		gaps_on = 1'b1;
	endtask

	task automatic test_drain_pause();
		set_config(FMT_S16, CH_W'(2));
		send_random(21, 1000);
		wait_drained();
		send_random(19, 1000);
	endtask

	// result side ready
	initial begin : result_sink
		int stall_left;
		stall_left = 0;
		forever begin
			@(negedge clk);
			if (sink_hold_len > 0) begin
				m_tready <= 1'b0;
				repeat (sink_hold_len) @(negedge clk);
				sink_hold_len = 0;
				m_tready <= 1'b1;
			end else if (stall_left > 0) begin
				m_tready <= 1'b0;
				stall_left--;
			end else begin
				m_tready <= 1'b1;
				stall_left = pick_gap();
			end
		end
	end

	always @(posedge clk) begin
		logic signed [SAMPLE_W-1:0] want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_mono.size() == 0) begin
				note_error($sformatf("unexpected mono_sample %0d", m_tdata));
			end else begin
				want = pending_mono.pop_front();
				if (m_tdata !== want)
					note_error($sformatf("mono_sample got %0d expected %0d", m_tdata, want));
			end
		end
	end

	initial begin : watchdog
		#10_000_000;
		$display("TEST FAILED");
		$finish;
	end

	initial begin : main
		cur_format   = FORMAT_RESET;
		cur_channels = CHANNEL_RESET;
		clear_alignment();
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_reset_settings();
		test_format_codes();
		test_channel_limits();
		test_partial_frames();
		test_random_phases();
		test_output_backpressure();
		test_drain_pause();
		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (pending_mono.size() != 0)
			note_error($sformatf("%0d mono samples never arrived", pending_mono.size()));
		if (err_count == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule

// ===== files.f =====
hw/rtl/pfdn_pkg.sv
hw/rtl/pfdn_div.sv
hw/rtl/pfdn_datapath.sv
hw/rtl/pfdn_ctrl.sv
hw/rtl/pcm_frame_downmix_normalizer_top.sv
sim/pcm_frame_downmix_normalizer_top_tb.sv
